[hw/rtl/mhead_pkg.sv]
// ----------------------------------------------------------------------------
// mhead_pkg
// shared constants, payload types and arctangent table for the heading core
// ----------------------------------------------------------------------------
package mhead_pkg;

    localparam int CORDIC_STEPS    = 16;
    localparam int ANGLE_FRAC_BITS = 6;
    localparam int TABLE_LEN       = 24;
    localparam int TABLE_FRAC      = 24;
    localparam int NSTEPS          = (CORDIC_STEPS < TABLE_LEN) ? CORDIC_STEPS : TABLE_LEN;
    localparam int UNIT_LOG2       = 6 + ANGLE_FRAC_BITS;
    localparam int TABLE_SHIFT     = TABLE_FRAC - UNIT_LOG2;

    localparam int RAW_W  = 16;
    localparam int DIFF_W = 17;
    localparam int GAIN_W = 24;
    localparam int DECL_W = 15;
    localparam int HEAD_W = 15;
    localparam int PW     = 41;
    localparam int XW     = PW + 2;
    localparam int ZW     = UNIT_LOG2 + 11;
    localparam int HW     = UNIT_LOG2 + 9;

    localparam int OUT_FULL = 23040;

    localparam int MQ_AW    = 2;
    localparam int MQ_DEPTH = 1 << MQ_AW;
    localparam int OQ_AW    = 2;
    localparam int OQ_DEPTH = 1 << OQ_AW;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_X    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_Y    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_X      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_Y      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DECLINATION = 3'd4;

    localparam logic signed [RAW_W-1:0]  RST_OFFSET_X    = -16'sd159;
    localparam logic signed [RAW_W-1:0]  RST_OFFSET_Y    = 16'sd254;
    localparam logic [GAIN_W-1:0]        RST_GAIN_X      = 24'd12405;
    localparam logic [GAIN_W-1:0]        RST_GAIN_Y      = 24'd11940;
    localparam logic signed [DECL_W-1:0] RST_DECLINATION = 15'sd249;

    localparam logic signed [ZW-1:0] QUARTER_TURN = ZW'(90 << UNIT_LOG2);
    localparam logic signed [ZW-1:0] HALF_TURN    = ZW'(180 << UNIT_LOG2);
    localparam logic signed [ZW-1:0] THREE_QUARTER = ZW'(270 << UNIT_LOG2);
    localparam logic signed [ZW-1:0] FULL_TURN    = ZW'(360 << UNIT_LOG2);

    typedef struct packed {
        logic                 bypass;
        logic signed [XW-1:0] x;
        logic signed [XW-1:0] y;
        logic signed [ZW-1:0] z;
    } t_mid;

    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

    // atan(2^-i) in degrees, rounded half up to the angle unit
    function automatic logic signed [ZW-1:0] atan_unit(input int idx);
        logic [31:0] v;
        case (idx)
            0:  v = 32'd754974720;
            1:  v = 32'd445687602;
            2:  v = 32'd235489088;
            3:  v = 32'd119537938;
            4:  v = 32'd60000934;
            5:  v = 32'd30029717;
            6:  v = 32'd15018523;
            7:  v = 32'd7509720;
            8:  v = 32'd3754917;
            9:  v = 32'd1877466;
            10: v = 32'd938734;
            11: v = 32'd469371;
            12: v = 32'd234685;
            13: v = 32'd117343;
            14: v = 32'd58671;
            15: v = 32'd29336;
            16: v = 32'd14668;
            17: v = 32'd7334;
            18: v = 32'd3667;
            19: v = 32'd1833;
            20: v = 32'd917;
            21: v = 32'd458;
            22: v = 32'd229;
            23: v = 32'd115;
            default: v = 32'd0;
        endcase
        return ZW'((v + (32'd1 << (TABLE_SHIFT - 1))) >> TABLE_SHIFT);
    endfunction

endpackage

[hw/rtl/mhead_front.sv]
// ----------------------------------------------------------------------------
// mhead_front
// offset removal, gain multiply and quadrant / axis classification
// ----------------------------------------------------------------------------
module mhead_front (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_push,
    input  logic signed [mhead_pkg::RAW_W-1:0]    i_raw_x,
    input  logic signed [mhead_pkg::RAW_W-1:0]    i_raw_y,
    input  logic signed [mhead_pkg::RAW_W-1:0]    i_offset_x,
    input  logic signed [mhead_pkg::RAW_W-1:0]    i_offset_y,
    input  logic [mhead_pkg::GAIN_W-1:0]          i_gain_x,
    input  logic [mhead_pkg::GAIN_W-1:0]          i_gain_y,
    input  mhead_pkg::t_qstat                     i_qstat,
    output logic                                  o_ready,
    output logic                                  o_qwr,
    output mhead_pkg::t_mid                       o_qdata
);
    import mhead_pkg::*;

    logic                     r_av;
    logic signed [DIFF_W-1:0] r_dx;
    logic signed [DIFF_W-1:0] r_dy;
    logic                     r_bv;
    logic signed [PW-1:0]     r_px;
    logic signed [PW-1:0]     r_py;

    logic                     w_adv;
    logic signed [GAIN_W:0]   w_gx;
    logic signed [GAIN_W:0]   w_gy;
    logic signed [PW:0]       w_mx;
    logic signed [PW:0]       w_my;
    logic signed [XW-1:0]     w_xe;
    logic signed [XW-1:0]     w_ye;

    assign w_adv   = !r_bv || !i_qstat.full;
    assign o_ready = w_adv;
    assign o_qwr   = r_bv && w_adv;

    assign w_gx = $signed({1'b0, i_gain_x});
    assign w_gy = $signed({1'b0, i_gain_y});
    assign w_mx = r_dx * w_gx;
    assign w_my = r_dy * w_gy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_av <= 1'b0;
            r_bv <= 1'b0;
        end else if (w_adv) begin
            r_av <= i_push;
            r_bv <= r_av;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_dx <= DIFF_W'(i_raw_x) - DIFF_W'(i_offset_x);
            r_dy <= DIFF_W'(i_raw_y) - DIFF_W'(i_offset_y);
            r_px <= w_mx[PW-1:0];
            r_py <= w_my[PW-1:0];
        end
    end

    assign w_xe = XW'(r_px);
    assign w_ye = XW'(r_py);

    // left half plane is folded over by negating both axes
    always_comb begin
        o_qdata = '0;
        if (r_py == '0) begin
            o_qdata.bypass = 1'b1;
            o_qdata.z      = r_px[PW-1] ? HALF_TURN : '0;
        end else if (r_px == '0) begin
            o_qdata.bypass = 1'b1;
            o_qdata.z      = r_py[PW-1] ? THREE_QUARTER : QUARTER_TURN;
        end else begin
            o_qdata.bypass = 1'b0;
            o_qdata.x      = r_px[PW-1] ? -w_xe : w_xe;
            o_qdata.y      = r_px[PW-1] ? -w_ye : w_ye;
            o_qdata.z      = r_px[PW-1] ? HALF_TURN : '0;
        end
    end

endmodule

[hw/rtl/mhead_queue.sv]
// ----------------------------------------------------------------------------
// mhead_queue
// short queue between the front and the cordic back end
// ----------------------------------------------------------------------------
module mhead_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_wr,
    input  mhead_pkg::t_mid    i_wdata,
    input  logic               i_rd,
    output mhead_pkg::t_mid    o_rdata,
    output mhead_pkg::t_qstat  o_stat
);
    import mhead_pkg::*;

    logic [MQ_AW-1:0] r_wptr;
    logic [MQ_AW-1:0] r_rptr;
    logic [MQ_AW:0]   r_cnt;
    t_mid             r_mem [MQ_DEPTH];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (i_wr) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (i_rd) begin
                r_rptr <= r_rptr + 1'b1;
            end
            case ({i_wr, i_rd})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wptr] <= i_wdata;
        end
    end

    assign o_rdata      = r_mem[r_rptr];
    assign o_stat.full  = (r_cnt == (MQ_AW + 1)'(MQ_DEPTH));
    assign o_stat.empty = (r_cnt == '0);

endmodule

[hw/rtl/mhead_back.sv]
// ----------------------------------------------------------------------------
// mhead_back
// cordic vectoring pipeline, declination, wrap, rounding and result queue
// ----------------------------------------------------------------------------
module mhead_back (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  mhead_pkg::t_mid                      i_head,
    input  mhead_pkg::t_qstat                    i_qstat,
    output logic                                 o_qrd,
    input  logic signed [mhead_pkg::DECL_W-1:0]  i_decl,
    input  logic                                 i_pop,
    output logic                                 o_empty,
    output logic [mhead_pkg::HEAD_W-1:0]         o_heading
);
    import mhead_pkg::*;

    localparam int QW = HW + 1 - ANGLE_FRAC_BITS;

    t_mid                 r_st [NSTEPS];
    logic [NSTEPS-1:0]    r_sv;
    t_mid                 w_in [NSTEPS];
    t_mid                 w_nx [NSTEPS];

    logic                 r_sumv;
    logic signed [ZW-1:0] r_sum;
    logic                 r_wrapv;
    logic [HW-1:0]        r_wrap;

    logic                 w_adv;
    logic signed [ZW-1:0] w_dext;
    logic signed [ZW-1:0] w_wrap;
    logic [HW:0]          w_rnd;
    logic [QW-1:0]        w_q;
    logic [HEAD_W-1:0]    w_head;

    logic [OQ_AW-1:0]     r_owptr;
    logic [OQ_AW-1:0]     r_orptr;
    logic [OQ_AW:0]       r_ocnt;
    logic [HEAD_W-1:0]    r_omem [OQ_DEPTH];
    logic                 w_ofull;
    logic                 w_opush;
    logic                 w_opop;

    // whole pipeline holds only when a finished result cannot enter the queue
    assign w_adv   = !(r_wrapv && w_ofull);
    assign o_qrd   = w_adv && !i_qstat.empty;
    assign w_opush = r_wrapv && w_adv;

    always_comb begin
        w_in[0] = i_head;
        for (int k = 1; k < NSTEPS; k++) begin
            w_in[k] = r_st[k-1];
        end
    end

    always_comb begin
        for (int k = 0; k < NSTEPS; k++) begin
            w_nx[k] = w_in[k];
            if (!w_in[k].bypass) begin
                if (w_in[k].y > 0) begin
                    w_nx[k].x = w_in[k].x + (w_in[k].y >>> k);
                    w_nx[k].y = w_in[k].y - (w_in[k].x >>> k);
                    w_nx[k].z = w_in[k].z + atan_unit(k);
                end else begin
                    w_nx[k].x = w_in[k].x - (w_in[k].y >>> k);
                    w_nx[k].y = w_in[k].y + (w_in[k].x >>> k);
                    w_nx[k].z = w_in[k].z - atan_unit(k);
                end
            end
        end
    end

    assign w_dext = ZW'(i_decl);

    always_comb begin
        if (r_sum < 0) begin
            w_wrap = r_sum + FULL_TURN;
        end else if (r_sum >= FULL_TURN) begin
            w_wrap = r_sum - FULL_TURN;
        end else begin
            w_wrap = r_sum;
        end
    end

    assign w_rnd  = {1'b0, r_wrap} + (HW + 1)'(1 << (ANGLE_FRAC_BITS - 1));
    assign w_q    = w_rnd[HW:ANGLE_FRAC_BITS];
    // full-turn edge wraps to zero
    assign w_head = (w_q >= QW'(OUT_FULL)) ? '0 : w_q[HEAD_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sv    <= '0;
            r_sumv  <= 1'b0;
            r_wrapv <= 1'b0;
        end else if (w_adv) begin
            r_sv    <= {r_sv[NSTEPS-2:0], !i_qstat.empty};
            r_sumv  <= r_sv[NSTEPS-1];
            r_wrapv <= r_sumv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int k = 0; k < NSTEPS; k++) begin
                r_st[k] <= w_nx[k];
            end
            r_sum  <= r_st[NSTEPS-1].z + (w_dext <<< ANGLE_FRAC_BITS);
            r_wrap <= w_wrap[HW-1:0];
        end
    end

    // result queue
    assign w_ofull = (r_ocnt == (OQ_AW + 1)'(OQ_DEPTH));
    assign o_empty = (r_ocnt == '0);
    assign w_opop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_owptr <= '0;
            r_orptr <= '0;
            r_ocnt  <= '0;
        end else begin
            if (w_opush) begin
                r_owptr <= r_owptr + 1'b1;
            end
            if (w_opop) begin
                r_orptr <= r_orptr + 1'b1;
            end
            case ({w_opush, w_opop})
                2'b10:   r_ocnt <= r_ocnt + 1'b1;
                2'b01:   r_ocnt <= r_ocnt - 1'b1;
                default: r_ocnt <= r_ocnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_opush) begin
            r_omem[r_owptr] <= w_head;
        end
    end

    assign o_heading = r_omem[r_orptr];

endmodule

[hw/rtl/magnetometer_heading_core.sv]
// ----------------------------------------------------------------------------
// magnetometer_heading_core: compass heading from an x/y magnetometer sample
// a sample passes the front registers, middle queue, cordic stages, sum and wrap registers and result queue
// throughput one sample per cycle while results can enter the result queue: one pipeline stage per cordic iteration
// reset clears the queues and pipeline and loads the default calibration
// ----------------------------------------------------------------------------
module magnetometer_heading_core (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  logic                                      push,
    output logic                                      full,
    input  logic signed [mhead_pkg::RAW_W-1:0]        i_raw_x,
    input  logic signed [mhead_pkg::RAW_W-1:0]        i_raw_y,
    output logic                                      empty,
    input  logic                                      pop,
    output logic [mhead_pkg::HEAD_W-1:0]              o_heading,
    input  logic                                      i_cfg_valid,
    output logic                                      o_cfg_ready,
    input  logic [mhead_pkg::CFG_IDX_W-1:0]           i_cfg_index,
    input  logic [mhead_pkg::CFG_DATA_W-1:0]          i_cfg_data
);
    import mhead_pkg::*;

    logic signed [RAW_W-1:0]  r_offset_x;
    logic signed [RAW_W-1:0]  r_offset_y;
    logic [GAIN_W-1:0]        r_gain_x;
    logic [GAIN_W-1:0]        r_gain_y;
    logic signed [DECL_W-1:0] r_decl;

    logic   w_ready;
    logic   w_qwr;
    logic   w_qrd;
    t_mid   w_qwdata;
    t_mid   w_qrdata;
    t_qstat w_qstat;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset_x <= RST_OFFSET_X;
            r_offset_y <= RST_OFFSET_Y;
            r_gain_x   <= RST_GAIN_X;
            r_gain_y   <= RST_GAIN_Y;
            r_decl     <= RST_DECLINATION;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_OFFSET_X:    r_offset_x <= i_cfg_data[RAW_W-1:0];
                REG_OFFSET_Y:    r_offset_y <= i_cfg_data[RAW_W-1:0];
                REG_GAIN_X:      r_gain_x   <= i_cfg_data[GAIN_W-1:0];
                REG_GAIN_Y:      r_gain_y   <= i_cfg_data[GAIN_W-1:0];
                REG_DECLINATION: r_decl     <= i_cfg_data[DECL_W-1:0];
                default: ;
            endcase
        end
    end

    assign full = !w_ready;

    mhead_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_raw_x    (i_raw_x),
        .i_raw_y    (i_raw_y),
        .i_offset_x (r_offset_x),
        .i_offset_y (r_offset_y),
        .i_gain_x   (r_gain_x),
        .i_gain_y   (r_gain_y),
        .i_qstat    (w_qstat),
        .o_ready    (w_ready),
        .o_qwr      (w_qwr),
        .o_qdata    (w_qwdata)
    );

    mhead_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (w_qwr),
        .i_wdata (w_qwdata),
        .i_rd    (w_qrd),
        .o_rdata (w_qrdata),
        .o_stat  (w_qstat)
    );

    mhead_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_head    (w_qrdata),
        .i_qstat   (w_qstat),
        .o_qrd     (w_qrd),
        .i_decl    (r_decl),
        .i_pop     (pop),
        .o_empty   (empty),
        .o_heading (o_heading)
    );

    a_head_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_heading < HEAD_W'(OUT_FULL)))
        else $error("heading outside full turn");

    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> (empty && !full))
        else $error("queues not clear after reset");

    a_full_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        full |-> w_qstat.full)
        else $error("input stalled while middle queue has room");

    a_no_read_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_qrd |-> !w_qstat.empty)
        else $error("back end read from empty middle queue");

endmodule

[dv/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: testbench for magnetometer_heading_core
// drives raw x/y samples through the push/full side and pops headings with
// random pacing; every popped heading is checked against a typed value or an
// in-bench model of the calibration, cordic and wrap arithmetic, under several calibrations
// ----------------------------------------------------------------------------
module tb;
    import mhead_pkg::*;

    localparam int HEAD_LATENCY = NSTEPS + 5;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int PHASES       = 8;
    localparam int PHASE_ITEMS  = 190;
    localparam int DIR_ROWS     = 34;

    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 3'd7;

    localparam longint TURN_UNITS    = longint'(360) << UNIT_LOG2;
    localparam longint HALF_UNITS    = longint'(180) << UNIT_LOG2;
    localparam longint QUARTER_UNITS = longint'(90) << UNIT_LOG2;

    // atan(2^-i) in degrees scaled by 2^24
    localparam longint ATAN_STEP_Q24 [0:23] = '{
        754974720, 445687602, 235489088, 119537938, 60000934, 30029717,
        15018523, 7509720, 3754917, 1877466, 938734, 469371,
        234685, 117343, 58671, 29336, 14668, 7334,
        3667, 1833, 917, 458, 229, 115
    };

    typedef struct packed {
        logic                        is_cfg;
        logic [CFG_IDX_W-1:0]        idx;
        logic [CFG_DATA_W-1:0]       data;
        logic signed [RAW_W-1:0]     rx;
        logic signed [RAW_W-1:0]     ry;
        logic                        known;
        logic [HEAD_W-1:0]           heading;
    } t_dir_row;

    typedef struct {
        logic signed [RAW_W-1:0] rx;
        logic signed [RAW_W-1:0] ry;
        logic [HEAD_W-1:0]       heading;
    } t_sample;

    // offsets at reset are -159 / 254, declination 249
    localparam t_dir_row DIRECTED [0:DIR_ROWS-1] = '{
        '{1'b0, REG_OFFSET_X, 24'h0, -16'sd159, 16'sd254, 1'b1, 15'd249},
        '{1'b0, REG_OFFSET_X, 24'h0, 16'sd1000, 16'sd254, 1'b1, 15'd249},
        '{1'b0, REG_OFFSET_X, 24'h0, -16'sd1000, 16'sd254, 1'b1, 15'd11769},
        '{1'b0, REG_OFFSET_X, 24'h0, -16'sd159, 16'sd1000, 1'b1, 15'd6009},
        '{1'b0, REG_OFFSET_X, 24'h0, -16'sd159, -16'sd1000, 1'b1, 15'd17529},
        '{1'b0, REG_OFFSET_X, 24'h0, 16'sh7FFF, 16'sh7FFF, 1'b0, 15'd0},
        '{1'b0, REG_OFFSET_X, 24'h0, 16'sh8000, 16'sh8000, 1'b0, 15'd0},
        '{1'b0, REG_OFFSET_X, 24'h0, 16'sh8000, 16'sh7FFF, 1'b0, 15'd0},
        '{1'b0, REG_OFFSET_X, 24'h0, 16'sh7FFF, 16'sh8000, 1'b0, 15'd0},
        '{1'b1, REG_DECLINATION, 24'h003FFF, 16'sd0, 16'sd0, 1'b0, 15'd0},
        '{1'b0, REG_OFFSET_X, 24'h0, -16'sd159, 16'sd254, 1'b1, 15'd16383},
        '{1'b1, REG_DECLINATION, 24'hFFC000, 16'sd0, 16'sd0, 1'b0, 15'd0},
        '{1'b0, REG_OFFSET_X, 24'h0, -16'sd159, 16'sd254, 1'b1, 15'd6656},
        '{1'b1, REG_UNMAPPED, 24'hFFFFFF, 16'sd0, 16'sd0, 1'b0, 15'd0},
        '{1'b0, REG_OFFSET_X, 24'h0, -16'sd159, 16'sd254, 1'b1, 15'd6656},
        '{1'b1, REG_DECLINATION, 24'h007FFF, 16'sd0, 16'sd0, 1'b0, 15'd0},
        '{1'b0, REG_OFFSET_X, 24'h0, 16'sd1000, 16'sd254, 1'b1, 15'd23039},
        '{1'b1, REG_DECLINATION, 24'h000000, 16'sd0, 16'sd0, 1'b0, 15'd0},
        // just below the full turn, rounds up to 360 and wraps
        '{1'b0, REG_OFFSET_X, 24'h0, 16'sh7FFF, 16'sd253, 1'b0, 15'd0},
        '{1'b0, REG_OFFSET_X, 24'h0, -16'sd1000, 16'sd254, 1'b1, 15'd11520},
        '{1'b0, REG_OFFSET_X, 24'h0, 16'sd1000, 16'sd300, 1'b0, 15'd0},
        '{1'b1, REG_GAIN_X, 24'h000000, 16'sd0, 16'sd0, 1'b0, 15'd0},
        '{1'b0, REG_OFFSET_X, 24'h0, 16'sd1000, 16'sd1000, 1'b1, 15'd5760},
        '{1'b1, REG_GAIN_Y, 24'h000000, 16'sd0, 16'sd0, 1'b0, 15'd0},
        '{1'b0, REG_OFFSET_X, 24'h0, 16'sd1000, 16'sd1000, 1'b1, 15'd0},
        '{1'b1, REG_OFFSET_X, 24'hFF8000, 16'sd0, 16'sd0, 1'b0, 15'd0},
        '{1'b1, REG_OFFSET_Y, 24'h007FFF, 16'sd0, 16'sd0, 1'b0, 15'd0},
        '{1'b1, REG_GAIN_X, 24'hFFFFFF, 16'sd0, 16'sd0, 1'b0, 15'd0},
        '{1'b1, REG_GAIN_Y, 24'hFFFFFF, 16'sd0, 16'sd0, 1'b0, 15'd0},
        '{1'b0, REG_OFFSET_X, 24'h0, 16'sh7FFF, 16'sh8000, 1'b0, 15'd0},
        '{1'b0, REG_OFFSET_X, 24'h0, 16'sh8000, 16'sh7FFF, 1'b1, 15'd0},
        '{1'b0, REG_OFFSET_X, 24'h0, 16'sd0, 16'sd0, 1'b0, 15'd0},
        '{1'b0, REG_OFFSET_X, 24'h0, 16'sh8000, 16'sh8000, 1'b1, 15'd17280},
        '{1'b0, REG_OFFSET_X, 24'h0, 16'sh7FFF, 16'sh7FFF, 1'b1, 15'd0}
    };

    logic                        i_clk       = 1'b0;
    logic                        i_rst_n     = 1'b0;
    logic                        push        = 1'b0;
    logic                        pop         = 1'b0;
    logic signed [RAW_W-1:0]     i_raw_x     = '0;
    logic signed [RAW_W-1:0]     i_raw_y     = '0;
    logic                        i_cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]        i_cfg_index = REG_OFFSET_X;
    logic [CFG_DATA_W-1:0]       i_cfg_data  = '0;
    wire                         full;
    wire                         empty;
    wire                         o_cfg_ready;
    wire [HEAD_W-1:0]            o_heading;

    // calibration as the block should hold it
    logic signed [RAW_W-1:0]     cal_off_x;
    logic signed [RAW_W-1:0]     cal_off_y;
    logic [GAIN_W-1:0]           cal_gain_x;
    logic [GAIN_W-1:0]           cal_gain_y;
    logic signed [DECL_W-1:0]    cal_decl;

    t_sample pending_headings [$];
    int send_idle_pct  = 10;
    int recv_stall_pct = 10;
    int n_sent    = 0;
    int n_checked = 0;
    int n_cfg     = 0;
    int n_fail    = 0;
    int n_cycles  = 0;

    magnetometer_heading_core uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_raw_x     (i_raw_x),
        .i_raw_y     (i_raw_y),
        .empty       (empty),
        .pop         (pop),
        .o_heading   (o_heading),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    function automatic logic [HEAD_W-1:0] compass_heading(input logic signed [RAW_W-1:0] rx,
                                                          input logic signed [RAW_W-1:0] ry);
        longint px, py, xv, yv, xs, ys, z, h, q;
        px = (longint'(rx) - longint'(cal_off_x)) * longint'(cal_gain_x);
        py = (longint'(ry) - longint'(cal_off_y)) * longint'(cal_gain_y);
        z = 0;
        if (py == 0) begin
            z = (px < 0) ? HALF_UNITS : 0;
        end else if (px == 0) begin
            z = (py > 0) ? QUARTER_UNITS : 3 * QUARTER_UNITS;
        end else begin
            xv = px;
            yv = py;
            // left half plane: rotate by 180 first
            if (xv < 0) begin
                xv = -xv;
                yv = -yv;
                z  = HALF_UNITS;
            end
            for (int i = 0; i < NSTEPS; i++) begin
                xs = xv >>> i;
                ys = yv >>> i;
                h  = (ATAN_STEP_Q24[i] + (longint'(1) << (TABLE_SHIFT - 1))) >>> TABLE_SHIFT;
                if (yv > 0) begin
                    xv = xv + ys;
                    yv = yv - xs;
                    z  = z + h;
                end else begin
                    xv = xv - ys;
                    yv = yv + xs;
                    z  = z - h;
                end
            end
        end
        h = (z + (longint'(cal_decl) <<< ANGLE_FRAC_BITS)) % TURN_UNITS;
        if (h < 0) begin
            h = h + TURN_UNITS;
        end
        q = (h + (longint'(1) << (ANGLE_FRAC_BITS - 1))) >>> ANGLE_FRAC_BITS;
        if (q >= OUT_FULL) begin
            q = 0;
        end
        return q[HEAD_W-1:0];
    endfunction

    function automatic logic signed [RAW_W-1:0] rand_raw(input logic signed [RAW_W-1:0] off);
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 55) return RAW_W'($urandom);
        // close to the offset, where the corrected vector is tiny
        if (pick < 72) return off + RAW_W'($urandom_range(6)) - RAW_W'(3);
        // exactly on an axis
        if (pick < 88) return off;
        return pick[0] ? 16'sh7FFF : 16'sh8000;
    endfunction

    function automatic logic [CFG_DATA_W-1:0] rand_offset_data();
        int unsigned pick;
        logic [RAW_W-1:0] v;
        pick = $urandom_range(7);
        v = (pick == 0) ? 16'h8000 : (pick == 1) ? 16'h7FFF : RAW_W'($urandom);
        return {8'($urandom), v};
    endfunction

    function automatic logic [CFG_DATA_W-1:0] rand_gain_data();
        int unsigned pick;
        pick = $urandom_range(9);
        if (pick == 0) return '0;
        if (pick == 1) return '1;
        if (pick < 5) return CFG_DATA_W'($urandom_range(16383));
        return CFG_DATA_W'($urandom);
    endfunction

    task automatic wait_drained();
        push = 1'b0;
        while (pending_headings.size() != 0) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        wait_drained();
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            REG_OFFSET_X:    cal_off_x  = data[RAW_W-1:0];
            REG_OFFSET_Y:    cal_off_y  = data[RAW_W-1:0];
            REG_GAIN_X:      cal_gain_x = data[GAIN_W-1:0];
            REG_GAIN_Y:      cal_gain_y = data[GAIN_W-1:0];
            REG_DECLINATION: cal_decl   = data[DECL_W-1:0];
            default: ;
        endcase
        n_cfg++;
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic randomise_cal();
        int unsigned pick;
        logic [DECL_W-1:0] d;
        write_reg(REG_OFFSET_X, rand_offset_data());
        write_reg(REG_OFFSET_Y, rand_offset_data());
        write_reg(REG_GAIN_X, rand_gain_data());
        write_reg(REG_GAIN_Y, rand_gain_data());
        pick = $urandom_range(7);
        case (pick)
            0: d = 15'h3FFF;
            1: d = 15'h4000;
            2: d = -15'sd11520;
            3: d = 15'sd11519;
            default: d = DECL_W'($urandom);
        endcase
        write_reg(REG_DECLINATION, {9'($urandom), d});
        if ($urandom_range(1)) begin
            write_reg(CFG_IDX_W'($urandom_range(REG_UNMAPPED, REG_DECLINATION + 1)),
                      CFG_DATA_W'($urandom));
        end
    endtask

    // called at a falling edge, returns at the falling edge after the transfer
    task automatic push_sample(input logic signed [RAW_W-1:0] rx,
                               input logic signed [RAW_W-1:0] ry,
                               input logic known, input logic [HEAD_W-1:0] typed);
        t_sample s;
        while ($urandom_range(99) < send_idle_pct) begin
            push = 1'b0;
            @(negedge i_clk);
        end
        push    = 1'b1;
        i_raw_x = rx;
        i_raw_y = ry;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        s.rx      = rx;
        s.ry      = ry;
        s.heading = known ? typed : compass_heading(rx, ry);
        pending_headings.push_back(s);
        n_sent++;
        @(negedge i_clk);
    endtask

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            pop <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        t_sample want;
        if (i_rst_n && pop && !empty) begin
            if (pending_headings.size() == 0) begin
                n_fail++;
                $display("%0t: heading %0d popped, expected none", $time, o_heading);
            end else begin
                want = pending_headings.pop_front();
                n_checked++;
                if (o_heading !== want.heading) begin
                    n_fail++;
                    $display("%0t: heading for x=%0d y=%0d: expected %0d, got %0d",
                             $time, want.rx, want.ry, want.heading, o_heading);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        n_cycles++;
        if (n_cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d headings outstanding",
                     n_cycles, pending_headings.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        t_dir_row row;
        cal_off_x  = RST_OFFSET_X;
        cal_off_y  = RST_OFFSET_Y;
        cal_gain_x = RST_GAIN_X;
        cal_gain_y = RST_GAIN_Y;
        cal_decl   = RST_DECLINATION;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        for (int r = 0; r < DIR_ROWS; r++) begin
            row = DIRECTED[r];
            if (row.is_cfg) begin
                write_reg(row.idx, row.data);
            end else begin
                push_sample(row.rx, row.ry, row.known, row.heading);
            end
        end

        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 63; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 63; end
                default: begin send_idle_pct = 10; recv_stall_pct = 10; end
            endcase
            randomise_cal();
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // hold off mid-phase until the pipe has emptied
                if (n == PHASE_ITEMS / 2) begin
                    wait_drained();
                end
                push_sample(rand_raw(cal_off_x), rand_raw(cal_off_y), 1'b0, '0);
            end
        end

        wait_drained();
        repeat (HEAD_LATENCY + 8) @(negedge i_clk);

        $display("%0d samples pushed, %0d headings checked, %0d register writes",
                 n_sent, n_checked, n_cfg);
        $display("%0d random calibrations under free, sparse, stalled and jittered pacing",
                 PHASES);
        if (n_fail == 0 && pending_headings.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

[sim.f]
hw/rtl/mhead_pkg.sv
hw/rtl/mhead_front.sv
hw/rtl/mhead_queue.sv
hw/rtl/mhead_back.sv
hw/rtl/magnetometer_heading_core.sv
dv/tb.sv
